// ===== rtl/icpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icpl_pkg: shared types and constants for the internet checksum block
// Protocol kinds, register map, pseudo-header terms and the ones-complement
// adder used by the datapath.
// ----------------------------------------------------------------------------
package icpl_pkg;

   localparam int COUNT_BITS = 16;

   // APB register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_PROTOCOL_KIND = 1'b0;

   typedef enum logic [1:0] {
      KIND_IP  = 2'd0,
      KIND_UDP = 2'd1,
      KIND_TCP = 2'd2
   } kind_type;

   localparam logic [15:0] UDP_PROTO = 16'd17;
   localparam logic [15:0] TCP_PROTO = 16'd6;
   localparam logic [15:0] LEN_BIAS  = 16'd8;

   // Ones-complement sum of four words with end-around carry.
   function automatic logic [15:0] oc_sum4(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
      logic [17:0] total;
      logic [16:0] fold;
      total = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      fold  = {1'b0, total[15:0]} + {15'd0, total[17:16]};
      return fold[15:0] + {15'd0, fold[16]};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/icpl_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icpl_if: request and response channels of the checksum block
// Valid/ready channels; a request or response moves when both are high.
// ----------------------------------------------------------------------------
interface icpl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface icpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] checksum_value;

   modport source (output valid, output checksum_value, input ready);
   modport sink   (input valid, input checksum_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/icpl_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icpl_csr: APB register file of the checksum block
// Holds the protocol kind register; zero wait states.
// ----------------------------------------------------------------------------
module icpl_csr
   import icpl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [1:0]            protocol_kind
);

   logic [1:0] kind_ff;
   logic       wr_en;
   logic       hit_kind;

   assign pready   = 1'b1;
   assign hit_kind = (paddr[2] == REG_PROTOCOL_KIND);
   assign wr_en    = psel && penable && pwrite && pready && hit_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_IP;
      end else if (wr_en) begin
         kind_ff <= pwdata[1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (hit_kind) begin
         prdata = {{(CSR_DATA_W-2){1'b0}}, kind_ff};
      end
   end

   assign protocol_kind = kind_ff;

endmodule
`default_nettype wire

// ===== rtl/internet_checksum_with_pseudo_length.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// internet_checksum_with_pseudo_length: streaming RFC 1071 checksum
// Byte-wide ones-complement checksum with optional UDP/TCP length terms.
// ----------------------------------------------------------------------------
// The block takes one packet byte per request and accepts a new request in
// every clock cycle, also while a finished checksum waits on the response
// channel; it stalls only when a further last byte reaches the input register
// while the previous checksum is still untaken. Bytes pair big-endian into
// 16-bit words (first byte high) that are added into a ones-complement running
// sum; an odd final byte is padded with a zero low byte. On the request marked
// last, the protocol_kind register (0 plain IP, 1 UDP, 2 TCP, 3 treated as
// plain IP) selects whether the protocol number and the length term (byte
// count - 8, modulo 65536) are added too, and the inverted sum is returned as
// one response. The last byte waits in the input register, and the four-term
// ones-complement adder then loads the checksum into the result register, which
// drives the response; the byte stays there while the previous one is untaken.
// Throughput is one byte per cycle while no untaken checksum holds a last byte.
// Write protocol_kind only between packets; it is sampled on the last byte.
// ----------------------------------------------------------------------------
module internet_checksum_with_pseudo_length
   import icpl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   icpl_req_if.sink                   req_chan,
   icpl_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [1:0] protocol_kind;

   icpl_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .protocol_kind (protocol_kind)
   );

   // Input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // Packet state
   logic [15:0]           sum_ff;
   logic [15:0]           sum_in;
   logic [7:0]            held_ff;
   logic                  odd_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   // Result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff;
   logic [15:0] rsp_value_in;

   logic        req_accept;
   logic        advance;
   logic [15:0] word;
   logic [15:0] word_term;
   logic [15:0] len_term;
   logic [15:0] proto_term;
   logic [15:0] len_sel;

   // Advance the buffered byte unless it closes a packet and the result
   // register still holds an untaken checksum.
   assign advance    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last;
      end
   end

   // Word assembly: complete a held pair, or pad a lone final byte.
   assign word      = odd_ff ? {held_ff, s1_byte_ff} : {s1_byte_ff, 8'h00};
   assign word_term = (odd_ff || s1_last_ff) ? word : 16'h0000;
   assign count_in  = count_ff + 1'b1;
   assign len_term  = 16'(count_in) - LEN_BIAS;

   // Pseudo-header terms picked by the protocol kind; unused code adds none.
   always_comb begin
      unique case (protocol_kind)
         KIND_UDP: begin
            proto_term = UDP_PROTO;
            len_sel    = len_term;
         end
         KIND_TCP: begin
            proto_term = TCP_PROTO;
            len_sel    = len_term;
         end
         default: begin
            proto_term = 16'h0000;
            len_sel    = 16'h0000;
         end
      endcase
   end

   assign sum_in       = oc_sum4(sum_ff, word_term, 16'h0000, 16'h0000);
   assign rsp_value_in = oc_sum4(sum_ff, word_term, proto_term, len_sel) ^ 16'hFFFF;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         held_ff  <= '0;
         odd_ff   <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         if (s1_last_ff) begin
            // Drop all packet state for the next packet.
            sum_ff   <= '0;
            held_ff  <= '0;
            odd_ff   <= 1'b0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            if (odd_ff) begin
               held_ff <= '0;
               odd_ff  <= 1'b0;
            end else begin
               held_ff <= s1_byte_ff;
               odd_ff  <= 1'b1;
            end
         end
      end
   end

   // Hold the checksum until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_last_ff) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.checksum_value = rsp_value_ff;

endmodule
`default_nettype wire

// ===== sim/internet_checksum_with_pseudo_length_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// internet_checksum_with_pseudo_length_tb: self-checking bench for the checksum
// Streams packets byte by byte through the request channel and predicts each
// checksum in a local ones-complement model. Every response is compared with
// the oldest prediction. The protocol kind is rewritten over APB between
// phases, and once in the middle of a packet. Both channels idle in random
// bursts.
// ----------------------------------------------------------------------------
module internet_checksum_with_pseudo_length_tb;
   import icpl_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PROTOCOL_KIND = CSR_ADDR_W'(4 * REG_PROTOCOL_KIND);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } byte_req_type;

   logic clock;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   icpl_req_if req_bus ();
   icpl_rsp_if rsp_bus ();

   internet_checksum_with_pseudo_length DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Bytes waiting to be sent and checksums waiting to come back.
   byte_req_type byte_queue[$];
   logic [15:0]  checksum_queue[$];

   // Local copy of the block state and of its register.
   logic [15:0]           sum_acc;
   logic [7:0]            held_byte;
   logic                  odd_pos;
   logic [COUNT_BITS-1:0] byte_cnt;
   logic [1:0]            kind_shadow;

   // Idle rate out of 16 on both channels; zero turns idling off.
   int unsigned idle_rate;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   int unsigned fail_count;

   byte_req_type next_req;
   logic [15:0]  want_sum;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ones-complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Advance the local state by one accepted byte; on the last byte, push the
   // checksum that the block must return.
   task automatic absorb_byte(input logic [7:0] b, input logic is_last);
      logic [COUNT_BITS-1:0] cnt_next;
      logic [15:0]           total;
      logic [15:0]           len_term;
      cnt_next = byte_cnt + 1'b1;
      if (odd_pos) begin
         sum_acc   = ones_add(sum_acc, {held_byte, b});
         odd_pos   = 1'b0;
         held_byte = 8'h00;
      end else if (is_last) begin
         // odd final byte: pad with a zero low byte
         sum_acc = ones_add(sum_acc, {b, 8'h00});
      end else begin
         held_byte = b;
         odd_pos   = 1'b1;
      end
      if (!is_last) begin
         byte_cnt = cnt_next;
      end else begin
         // length term wraps to 16 bits, so short packets add a large value
         len_term = 16'(cnt_next) - LEN_BIAS;
         total    = sum_acc;
         if (kind_shadow == KIND_UDP) begin
            total = ones_add(ones_add(total, UDP_PROTO), len_term);
         end else if (kind_shadow == KIND_TCP) begin
            total = ones_add(ones_add(total, TCP_PROTO), len_term);
         end
         checksum_queue.push_back(total ^ 16'hFFFF);
         sum_acc   = 16'h0000;
         held_byte = 8'h00;
         odd_pos   = 1'b0;
         byte_cnt  = '0;
      end
   endtask

   // Driver: present queued bytes, with random gaps before a new request.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_byte(req_bus.data_byte, req_bus.last);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left == 0 && byte_queue.size() > 0 && idle_rate > 0 &&
                $urandom_range(0, 15) < idle_rate) begin
               gap_left = $urandom_range(1, 10);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               next_req = byte_queue.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= next_req.data_byte;
               req_bus.last      <= next_req.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response against the oldest prediction and stall
   // the response channel in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (checksum_queue.size() == 0) begin
               $error("unexpected response: checksum_value %h", rsp_bus.checksum_value);
               fail_count++;
            end else begin
               want_sum = checksum_queue.pop_front();
               if (rsp_bus.checksum_value !== want_sum) begin
                  $error("checksum_value mismatch: expected %h, actual %h",
                         want_sum, rsp_bus.checksum_value);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_rate > 0 && $urandom_range(0, 15) < idle_rate) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no activity for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic is_last);
      byte_req_type item;
      item.data_byte = b;
      item.last      = is_last;
      byte_queue.push_back(item);
   endtask

   // Queue one packet of random bytes; the final byte carries last.
   task automatic push_packet(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         push_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Hold until every byte is taken and every checksum is back, then let the
   // pipeline settle so a trailing non-last byte has been absorbed. Sample on
   // the falling edge so the driver and monitor updates have all landed.
   task automatic wait_idle();
      while (byte_queue.size() > 0 || req_bus.valid || checksum_queue.size() > 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle held until pready.
   task automatic write_kind(input logic [1:0] kind);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_PROTOCOL_KIND;
      pwdata  <= CSR_DATA_W'(kind);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      kind_shadow = kind;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      int unsigned phase_bytes;
      int unsigned len;
      clock       = 1'b0;
      reset       = 1'b1;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      sum_acc     = 16'h0000;
      held_byte   = 8'h00;
      odd_pos     = 1'b0;
      byte_cnt    = '0;
      kind_shadow = KIND_IP;
      idle_rate   = 0;
      fail_count  = 0;
      quiet_cycles = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: plain IP at reset value, all-ones word, single bytes.
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      wait_idle();

      // UDP with a short odd packet, length term wraps.
      write_kind(KIND_UDP);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(8'hAB, 1'b1);
      wait_idle();

      // TCP with a mixed short packet.
      write_kind(KIND_TCP);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b1);
      wait_idle();

      // Unused kind behaves as plain IP.
      write_kind(2'd3);
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b1);
      wait_idle();

      // Change the kind in the middle of a packet; only the last byte sees it.
      write_kind(KIND_UDP);
      push_byte(8'hDE, 1'b0);
      push_byte(8'hAD, 1'b0);
      push_byte(8'hBE, 1'b0);
      wait_idle();
      write_kind(KIND_TCP);
      push_byte(8'hEF, 1'b1);
      wait_idle();

      // Random phases: new kind and idle rate each time, mostly mid-size
      // packets with some short ones.
      for (int phase = 0; phase < 10; phase++) begin
         write_kind(2'($urandom_range(0, 3)));
         case ($urandom_range(0, 2))
            0: idle_rate = 0;
            1: idle_rate = 2;
            default: idle_rate = 6;
         endcase
         if (phase == 9) begin
            idle_rate = 0;
         end
         phase_bytes = 0;
         while (phase_bytes < 100) begin
            if ($urandom_range(0, 3) == 0) begin
               len = $urandom_range(1, 7);
            end else begin
               len = $urandom_range(8, 40);
            end
            push_packet(len);
            phase_bytes += len;
         end
         wait_idle();
      end

      // Drain: any late or extra response shows up in the monitor.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (checksum_queue.size() > 0) begin
         $error("%0d checksums never returned", checksum_queue.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== internet_checksum_with_pseudo_length.f =====
rtl/icpl_pkg.sv
rtl/icpl_if.sv
rtl/icpl_csr.sv
rtl/internet_checksum_with_pseudo_length.sv
sim/internet_checksum_with_pseudo_length_tb.sv
